### rtl/core/rmrc_pkg.sv
// ----------------------------------------------------------------------------
// rmrc_pkg
// Shared types, constants and CRC helpers for the Modbus RTU read reply
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rmrc_pkg;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [6:0]  MAX_REGS          = 7'd125;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_TIMEOUT   = 3'd1;
    localparam logic [2:0] STATUS_HEADER    = 3'd2;
    localparam logic [2:0] STATUS_CRC       = 3'd3;
    localparam logic [2:0] STATUS_NONFINITE = 3'd4;

    localparam logic [1:0] CFG_SLAVE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_REGISTER_COUNT = 2'd1;
    localparam logic [1:0] CFG_FIRST_VALUE    = 2'd2;
    localparam logic [1:0] CFG_SECOND_VALUE   = 2'd3;

    localparam logic [7:0] RST_SLAVE_ADDRESS  = 8'd1;
    localparam logic [6:0] RST_REGISTER_COUNT = 7'd22;
    localparam logic [6:0] RST_FIRST_VALUE    = 7'd0;
    localparam logic [6:0] RST_SECOND_VALUE   = 7'd20;

    typedef enum logic {
        OP_BYTE,
        OP_CLOSE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [6:0] register_count;
        logic [6:0] first_value_register;
        logic [6:0] second_value_register;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] first_value_word;
        logic [31:0] second_value_word;
        logic [15:0] computed_crc;
    } t_res;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [31:0] place_byte(input logic [31:0] word, input logic [1:0] pos,
                                               input logic [7:0] b);
        logic [31:0] w;
        w = word;
        case (pos)
            2'd0:    w[31:24] = b;
            2'd1:    w[23:16] = b;
            2'd2:    w[15:8]  = b;
            default: w[7:0]   = b;
        endcase
        return w;
    endfunction

    function automatic logic non_finite(input logic [31:0] w);
        return w[30:23] == 8'hFF;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rmrc_front.sv
// ----------------------------------------------------------------------------
// rmrc_front
// Input side: accepts bytes and window closes, tags each as an operation and
// holds it in a two-entry queue for the frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrc_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               push,
    output logic              full,
    input  wire               i_func,
    input  wire  [7:0]        i_rx_byte,
    output logic              o_valid,
    output rmrc_pkg::t_item   o_item,
    input  wire               i_take
);

    rmrc_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            n_wp;
    logic            n_rp;
    logic [1:0]      n_cnt;
    logic            push_ok;
    logic            take_ok;
    rmrc_pkg::t_item item_in;

    assign full    = (r_cnt == 2'd2);
    assign push_ok = push && !full;
    assign o_valid = (r_cnt != 2'd0);
    assign take_ok = i_take && o_valid;
    assign o_item  = r_q[r_rp];

    always_comb begin
        item_in.op   = i_func ? rmrc_pkg::OP_CLOSE : rmrc_pkg::OP_BYTE;
        item_in.data = i_rx_byte;
    end

    always_comb begin
        n_wp  = push_ok ? ~r_wp : r_wp;
        n_rp  = take_ok ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push_ok} - {1'b0, take_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= item_in;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rmrc_back.sv
// ----------------------------------------------------------------------------
// rmrc_back
// Frame engine: header check, CRC-16 per byte, value capture and verdict,
// with a two-entry result queue toward the reader.
// ----------------------------------------------------------------------------
`default_nettype none

module rmrc_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  rmrc_pkg::t_cfg    i_cfg,
    input  wire               i_valid,
    input  rmrc_pkg::t_item   i_item,
    output logic              o_take,
    output logic              empty,
    input  wire               pop,
    output rmrc_pkg::t_res    o_res
);

    logic [7:0]  r_byte_index;
    logic [15:0] r_crc;
    logic        r_header_good;
    logic [7:0]  r_crc_low;
    logic [31:0] r_first_asm;
    logic [31:0] r_second_asm;
    logic [31:0] r_last_first;
    logic [31:0] r_last_second;
    logic        r_frame_done;

    logic [7:0]  n_byte_index;
    logic [15:0] n_crc;
    logic        n_header_good;
    logic [7:0]  n_crc_low;
    logic [31:0] n_first_asm;
    logic [31:0] n_second_asm;
    logic [31:0] n_last_first;
    logic [31:0] n_last_second;
    logic        n_frame_done;

    rmrc_pkg::t_res r_oq [2];
    logic           r_owp;
    logic           r_orp;
    logic [1:0]     r_ocnt;

    logic [6:0]  rc;
    logic [7:0]  data_len;
    logic [7:0]  frame_len;
    logic [7:0]  dpos;
    logic [7:0]  start1;
    logic [7:0]  start2;
    logic [7:0]  diff1;
    logic [7:0]  diff2;
    logic        pop_ok;
    logic        res_valid;
    rmrc_pkg::t_res res;
    logic [2:0]  verdict;
    logic [15:0] pkt_crc;

    assign pop_ok = pop && (r_ocnt != 2'd0);
    assign empty  = (r_ocnt == 2'd0);
    assign o_res  = r_oq[r_orp];
    assign o_take = i_valid && ((r_ocnt != 2'd2) || pop_ok);

    assign rc        = (i_cfg.register_count > rmrc_pkg::MAX_REGS) ? rmrc_pkg::MAX_REGS
                                                                   : i_cfg.register_count;
    assign data_len  = {rc, 1'b0};
    assign frame_len = data_len + 8'd5;
    assign dpos      = r_byte_index - 8'd3;
    assign start1    = {i_cfg.first_value_register, 1'b0};
    assign start2    = {i_cfg.second_value_register, 1'b0};
    assign diff1     = dpos - start1;
    assign diff2     = dpos - start2;
    assign pkt_crc   = {i_item.data, r_crc_low};

    always_comb begin
        if (!r_header_good) begin
            verdict = rmrc_pkg::STATUS_HEADER;
        end else if (pkt_crc != r_crc) begin
            verdict = rmrc_pkg::STATUS_CRC;
        end else if (rmrc_pkg::non_finite(r_first_asm) ||
                     rmrc_pkg::non_finite(r_second_asm)) begin
            verdict = rmrc_pkg::STATUS_NONFINITE;
        end else begin
            verdict = rmrc_pkg::STATUS_OK;
        end
    end

    always_comb begin
        n_byte_index  = r_byte_index;
        n_crc         = r_crc;
        n_header_good = r_header_good;
        n_crc_low     = r_crc_low;
        n_first_asm   = r_first_asm;
        n_second_asm  = r_second_asm;
        n_last_first  = r_last_first;
        n_last_second = r_last_second;
        n_frame_done  = r_frame_done;
        res_valid     = 1'b0;
        res.status            = rmrc_pkg::STATUS_TIMEOUT;
        res.first_value_word  = r_last_first;
        res.second_value_word = r_last_second;
        res.computed_crc      = r_crc;
        if (o_take) begin
            if (i_item.op == rmrc_pkg::OP_CLOSE) begin
                res_valid     = !r_frame_done;
                n_byte_index  = 8'd0;
                n_crc         = rmrc_pkg::CRC_INIT;
                n_header_good = 1'b1;
                n_crc_low     = 8'd0;
                n_first_asm   = 32'd0;
                n_second_asm  = 32'd0;
                n_frame_done  = 1'b0;
            end else if (!r_frame_done && (r_byte_index < frame_len)) begin
                if ((r_byte_index == 8'd0) && (i_item.data != i_cfg.slave_address)) begin
                    n_header_good = 1'b0;
                end
                if ((r_byte_index == 8'd1) && (i_item.data != rmrc_pkg::FUNC_READ_HOLDING)) begin
                    n_header_good = 1'b0;
                end
                if ((r_byte_index == 8'd2) && (i_item.data != data_len)) begin
                    n_header_good = 1'b0;
                end
                if ((r_byte_index >= 8'd3) && (r_byte_index < data_len + 8'd3)) begin
                    if ((dpos >= start1) && (diff1 < 8'd4)) begin
                        n_first_asm = rmrc_pkg::place_byte(r_first_asm, diff1[1:0], i_item.data);
                    end
                    if ((dpos >= start2) && (diff2 < 8'd4)) begin
                        n_second_asm = rmrc_pkg::place_byte(r_second_asm, diff2[1:0],
                                                            i_item.data);
                    end
                end
                n_byte_index = r_byte_index + 8'd1;
                if (r_byte_index < frame_len - 8'd2) begin
                    n_crc = rmrc_pkg::crc_update(r_crc, i_item.data);
                end else if (r_byte_index == frame_len - 8'd2) begin
                    n_crc_low = i_item.data;
                end else begin
                    n_frame_done = 1'b1;
                    res_valid    = 1'b1;
                    res.status   = verdict;
                    if (verdict == rmrc_pkg::STATUS_OK) begin
                        n_last_first          = r_first_asm;
                        n_last_second         = r_second_asm;
                        res.first_value_word  = r_first_asm;
                        res.second_value_word = r_second_asm;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index  <= 8'd0;
            r_crc         <= rmrc_pkg::CRC_INIT;
            r_header_good <= 1'b1;
            r_crc_low     <= 8'd0;
            r_first_asm   <= 32'd0;
            r_second_asm  <= 32'd0;
            r_last_first  <= 32'd0;
            r_last_second <= 32'd0;
            r_frame_done  <= 1'b0;
            r_owp         <= 1'b0;
            r_orp         <= 1'b0;
            r_ocnt        <= 2'd0;
        end else begin
            r_byte_index  <= n_byte_index;
            r_crc         <= n_crc;
            r_header_good <= n_header_good;
            r_crc_low     <= n_crc_low;
            r_first_asm   <= n_first_asm;
            r_second_asm  <= n_second_asm;
            r_last_first  <= n_last_first;
            r_last_second <= n_last_second;
            r_frame_done  <= n_frame_done;
            r_owp         <= res_valid ? ~r_owp : r_owp;
            r_orp         <= pop_ok ? ~r_orp : r_orp;
            r_ocnt        <= r_ocnt + {1'b0, res_valid} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_oq[r_owp] <= res;
        end
    end

endmodule

`default_nettype wire

### rtl/core/modbus_rtu_read_reply_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_read_reply_checker
// Checks Modbus RTU read-holding-registers replies byte by byte and reports
// one verdict per frame or per empty reception window.
// ----------------------------------------------------------------------------
// Push one received byte (i_func low) or a window close (i_func high) per
// cycle while full is low; the block sustains one item per clock while the
// result queue is not full or is being popped. An item passes a two-entry
// input queue to the frame engine, which updates the CRC-16 a byte at a
// time; the verdict of a frame's last byte, or of a close without a
// completed frame, is registered into a two-entry result queue and waits
// there until popped. Write the registers (0 slave address, 1 register
// count, 2 and 3 value register offsets) only while no item is in flight.
`default_nettype none

module modbus_rtu_read_reply_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire         i_func,
    input  wire  [7:0]  i_rx_byte,
    output logic        empty,
    input  wire         pop,
    output logic [2:0]  o_status,
    output logic [31:0] o_first_value_word,
    output logic [31:0] o_second_value_word,
    output logic [15:0] o_computed_crc,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [7:0]  i_cfg_data
);

    rmrc_pkg::t_cfg  r_cfg;
    rmrc_pkg::t_item item;
    rmrc_pkg::t_res  res;
    logic            item_valid;
    logic            take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address         <= rmrc_pkg::RST_SLAVE_ADDRESS;
            r_cfg.register_count        <= rmrc_pkg::RST_REGISTER_COUNT;
            r_cfg.first_value_register  <= rmrc_pkg::RST_FIRST_VALUE;
            r_cfg.second_value_register <= rmrc_pkg::RST_SECOND_VALUE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rmrc_pkg::CFG_SLAVE_ADDRESS:  r_cfg.slave_address         <= i_cfg_data;
                rmrc_pkg::CFG_REGISTER_COUNT: r_cfg.register_count        <= i_cfg_data[6:0];
                rmrc_pkg::CFG_FIRST_VALUE:    r_cfg.first_value_register  <= i_cfg_data[6:0];
                rmrc_pkg::CFG_SECOND_VALUE:   r_cfg.second_value_register <= i_cfg_data[6:0];
                default:                      r_cfg <= r_cfg;
            endcase
        end
    end

    rmrc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_func    (i_func),
        .i_rx_byte (i_rx_byte),
        .o_valid   (item_valid),
        .o_item    (item),
        .i_take    (take)
    );

    rmrc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (item_valid),
        .i_item  (item),
        .o_take  (take),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res)
    );

    assign o_status            = res.status;
    assign o_first_value_word  = res.first_value_word;
    assign o_second_value_word = res.second_value_word;
    assign o_computed_crc      = res.computed_crc;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= rmrc_pkg::STATUS_NONFINITE))
        else $error("result status out of range");

    a_ok_first_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == rmrc_pkg::STATUS_OK)) |-> (o_first_value_word[30:23] != 8'hFF))
        else $error("accepted first word is non-finite");

    a_ok_second_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == rmrc_pkg::STATUS_OK)) |-> (o_second_value_word[30:23] != 8'hFF))
        else $error("accepted second word is non-finite");

endmodule

`default_nettype wire

### dv/tb_modbus_rtu_read_reply_checker.sv
// ----------------------------------------------------------------------------
// tb_modbus_rtu_read_reply_checker
// Self-checking testbench for the Modbus RTU read reply checker. Replies are
// built from the live register settings: well-formed, broken in the header,
// the CRC or the value words, cut short or padded, with random noise. Every
// accepted word feeds an in-bench verdict predictor. Each popped verdict is
// compared field by field against the oldest predicted one. Both sides idle
// at random.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_read_reply_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import rmrc_pkg::*;

    localparam int WORD_TARGET   = 1350;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;

    typedef enum {
        RP_GOOD,
        RP_BAD_ADDR,
        RP_BAD_FUNC,
        RP_BAD_COUNT,
        RP_BAD_ALL,
        RP_BAD_CRC,
        RP_NAN_FIRST,
        RP_NAN_SECOND,
        RP_NAN_BAD_CRC,
        RP_NEAR_NAN,
        RP_SHORT,
        RP_EXTRA
    } reply_kind_t;

    typedef enum {
        VS_FINITE,
        VS_NON_FINITE,
        VS_EDGE
    } value_shape_t;

    typedef enum {
        POP_FREE,
        POP_HALF,
        POP_SPARSE
    } pop_mode_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        push       = 1'b0;
    logic        full;
    logic        i_func     = 1'b0;
    logic [7:0]  i_rx_byte  = 8'h00;
    logic        empty;
    logic        pop        = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_first_value_word;
    logic [31:0] o_second_value_word;
    logic [15:0] o_computed_crc;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_addr = 2'd0;
    logic [7:0]  i_cfg_data = 8'h00;

    modbus_rtu_read_reply_checker dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_func              (i_func),
        .i_rx_byte           (i_rx_byte),
        .empty               (empty),
        .pop                 (pop),
        .o_status            (o_status),
        .o_first_value_word  (o_first_value_word),
        .o_second_value_word (o_second_value_word),
        .o_computed_crc      (o_computed_crc),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // verdict predictor state
    t_cfg        live_cfg;
    logic [7:0]  frame_pos;
    logic [15:0] crc_acc;
    logic        header_ok;
    logic [7:0]  crc_low;
    logic [31:0] first_acc;
    logic [31:0] second_acc;
    logic [31:0] first_good;
    logic [31:0] second_good;
    logic        frame_complete;
    t_res        expected_verdicts[$];

    logic [7:0]  reply_bytes[$];
    int          words_sent  = 0;
    int          errors      = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          gaps_on     = 1'b1;
    bit          hold_start  = 1'b0;
    int          hold_left   = 0;
    int          mode_left   = 0;
    pop_mode_t   pop_mode    = POP_FREE;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        repeat (8) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [31:0] merge_byte(input logic [31:0] w, input int d,
                                               input logic [6:0] reg_off, input logic [7:0] b);
        int start;
        start = 2 * int'(reg_off);
        if (d >= start && d < start + 4) begin
            w[(3 - (d - start)) * 8 +: 8] = b;
        end
        return w;
    endfunction

    function automatic logic exponent_full(input logic [31:0] w);
        return &w[30:23];
    endfunction

    function automatic int live_regs();
        return (live_cfg.register_count > MAX_REGS) ? int'(MAX_REGS)
                                                    : int'(live_cfg.register_count);
    endfunction

    function automatic void restart_window();
        frame_pos      = 8'd0;
        crc_acc        = CRC_INIT;
        header_ok      = 1'b1;
        crc_low        = 8'd0;
        first_acc      = 32'd0;
        second_acc     = 32'd0;
        frame_complete = 1'b0;
    endfunction

    function automatic void queue_verdict(input logic [2:0] st);
        t_res r;
        r.status            = st;
        r.first_value_word  = first_good;
        r.second_value_word = second_good;
        r.computed_crc      = crc_acc;
        expected_verdicts.push_back(r);
    endfunction

    function automatic void predict_verdict(input t_op op, input logic [7:0] b);
        int data_len;
        int frame_len;
        int i;
        data_len  = 2 * live_regs();
        frame_len = data_len + 5;
        i         = int'(frame_pos);
        if (op == OP_CLOSE) begin
            if (!frame_complete) begin
                queue_verdict(STATUS_TIMEOUT);
            end
            restart_window();
            return;
        end
        if (frame_complete || i >= frame_len) begin
            return;
        end
        if (i == 0 && b != live_cfg.slave_address) header_ok = 1'b0;
        if (i == 1 && b != FUNC_READ_HOLDING) header_ok = 1'b0;
        if (i == 2 && int'(b) != data_len) header_ok = 1'b0;
        if (i >= 3 && i < 3 + data_len) begin
            first_acc  = merge_byte(first_acc, i - 3, live_cfg.first_value_register, b);
            second_acc = merge_byte(second_acc, i - 3, live_cfg.second_value_register, b);
        end
        frame_pos = 8'(i + 1);
        if (i < frame_len - 2) begin
            crc_acc = crc16_byte(crc_acc, b);
        end else if (i == frame_len - 2) begin
            crc_low = b;
        end else begin
            frame_complete = 1'b1;
            if (!header_ok) begin
                queue_verdict(STATUS_HEADER);
            end else if ({b, crc_low} != crc_acc) begin
                queue_verdict(STATUS_CRC);
            end else if (exponent_full(first_acc) || exponent_full(second_acc)) begin
                queue_verdict(STATUS_NONFINITE);
            end else begin
                first_good  = first_acc;
                second_good = second_acc;
                queue_verdict(STATUS_OK);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < 40) begin
            $display("MISMATCH at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        end
        errors++;
    endtask

    // verdict checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("verdict with none pending, status", 32'(o_status), 32'd0);
            end else begin
                want = expected_verdicts.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_first_value_word !== want.first_value_word)
                    report_mismatch("first_value_word", o_first_value_word,
                                    want.first_value_word);
                if (o_second_value_word !== want.second_value_word)
                    report_mismatch("second_value_word", o_second_value_word,
                                    want.second_value_word);
                if (o_computed_crc !== want.computed_crc)
                    report_mismatch("computed_crc", 32'(o_computed_crc),
                                    32'(want.computed_crc));
            end
        end
    end

    // receiver: stall pattern plus requested long hold
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (mode_left == 0) begin
            pop_mode  = pop_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(5, 60);
        end else begin
            mode_left--;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            case (pop_mode)
                POP_FREE: pop <= 1'b1;
                POP_HALF: pop <= 1'($urandom_range(0, 1));
                default:  pop <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("modbus_rtu_read_reply_checker regression: fail");
            $finish;
        end
    end

    task automatic send_word(input t_op op, input logic [7:0] data);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 5);
            burst_left = $urandom_range(1, 10);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        push      <= 1'b1;
        i_func    <= op;
        i_rx_byte <= data;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_verdict(op, data);
        words_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SLAVE_ADDRESS:  live_cfg.slave_address         = val;
            CFG_REGISTER_COUNT: live_cfg.register_count        = val[6:0];
            CFG_FIRST_VALUE:    live_cfg.first_value_register  = val[6:0];
            default:            live_cfg.second_value_register = val[6:0];
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] addr, input logic [7:0] count,
                              input logic [7:0] off_a, input logic [7:0] off_b);
        drain();
        cfg_write(CFG_SLAVE_ADDRESS, addr);
        cfg_write(CFG_REGISTER_COUNT, count);
        cfg_write(CFG_FIRST_VALUE, off_a);
        cfg_write(CFG_SECOND_VALUE, off_b);
    endtask

    function automatic void shape_value(input logic [6:0] off, input int data_end,
                                        input value_shape_t shape);
        int p;
        p = 3 + 2 * int'(off);
        if (p < data_end) begin
            if (shape == VS_FINITE) reply_bytes[p] = reply_bytes[p] & 8'hBF;
            else reply_bytes[p] = reply_bytes[p] | 8'h7F;
        end
        if (p + 1 < data_end) begin
            if (shape == VS_NON_FINITE) reply_bytes[p + 1] = reply_bytes[p + 1] | 8'h80;
            if (shape == VS_EDGE) reply_bytes[p + 1] = reply_bytes[p + 1] & 8'h7F;
        end
    endfunction

    function automatic void build_reply(input reply_kind_t kind);
        int          rc;
        int          data_end;
        int          k;
        int          cut;
        logic [15:0] crc;
        rc       = live_regs();
        data_end = 3 + 2 * rc;
        reply_bytes.delete();
        reply_bytes.push_back(live_cfg.slave_address);
        reply_bytes.push_back(FUNC_READ_HOLDING);
        reply_bytes.push_back(8'(2 * rc));
        for (k = 0; k < 2 * rc; k++) reply_bytes.push_back(8'($urandom));
        shape_value(live_cfg.first_value_register, data_end,
                    (kind == RP_NAN_FIRST || kind == RP_NAN_BAD_CRC) ? VS_NON_FINITE :
                    (kind == RP_NEAR_NAN) ? VS_EDGE : VS_FINITE);
        shape_value(live_cfg.second_value_register, data_end,
                    (kind == RP_NAN_SECOND) ? VS_NON_FINITE : VS_FINITE);
        if (kind == RP_BAD_ADDR || kind == RP_BAD_ALL)
            reply_bytes[0] = reply_bytes[0] ^ 8'($urandom_range(1, 255));
        if (kind == RP_BAD_FUNC)
            reply_bytes[1] = FUNC_READ_HOLDING ^ 8'($urandom_range(1, 255));
        if (kind == RP_BAD_COUNT)
            reply_bytes[2] = reply_bytes[2] ^ 8'($urandom_range(1, 255));
        crc = CRC_INIT;
        foreach (reply_bytes[j]) crc = crc16_byte(crc, reply_bytes[j]);
        reply_bytes.push_back(crc[7:0]);
        reply_bytes.push_back(crc[15:8]);
        if (kind == RP_BAD_CRC || kind == RP_NAN_BAD_CRC || kind == RP_BAD_ALL) begin
            k = reply_bytes.size() - 1 - $urandom_range(0, 1);
            reply_bytes[k] = reply_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
        end
        if (kind == RP_SHORT) begin
            cut = $urandom_range(0, reply_bytes.size() - 1);
            while (reply_bytes.size() > cut) void'(reply_bytes.pop_back());
        end
        if (kind == RP_EXTRA) begin
            repeat ($urandom_range(1, 5)) reply_bytes.push_back(8'($urandom));
        end
    endfunction

    task automatic send_reply(input reply_kind_t kind);
        build_reply(kind);
        foreach (reply_bytes[k]) send_word(OP_BYTE, reply_bytes[k]);
        send_word(OP_CLOSE, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_offset(input int count);
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, (count > 124) ? 124 : count));
        return 8'($urandom_range(0, 124));
    endfunction

    task automatic test_reset_defaults();
        send_reply(RP_GOOD);
    endtask

    task automatic test_header_checks();
        set_config(8'h5A, 8'd1, 8'd0, 8'd0);
        send_reply(RP_BAD_ADDR);
        send_reply(RP_BAD_FUNC);
        send_reply(RP_BAD_COUNT);
        send_reply(RP_BAD_ALL);
    endtask

    task automatic test_crc_check();
        send_reply(RP_BAD_CRC);
        send_reply(RP_BAD_CRC);
        send_reply(RP_NAN_BAD_CRC);
        send_reply(RP_GOOD);
    endtask

    task automatic test_non_finite();
        set_config(8'd247, 8'd2, 8'd0, 8'd1);
        send_reply(RP_NAN_FIRST);
        send_reply(RP_NAN_SECOND);
        send_reply(RP_NEAR_NAN);
        send_reply(RP_GOOD);
    endtask

    task automatic test_window_close();
        send_word(OP_CLOSE, 8'hFF);
        send_word(OP_CLOSE, 8'h00);
        send_reply(RP_SHORT);
        send_reply(RP_EXTRA);
    endtask

    task automatic test_count_extremes();
        set_config(8'd1, 8'd0, 8'd0, 8'd0);
        send_reply(RP_GOOD);
        send_reply(RP_BAD_CRC);
        // count above the maximum, written with the top data bit set
        set_config(8'd200, 8'hFF, 8'd124, 8'd123);
        send_reply(RP_GOOD);
        set_config(8'd17, 8'd125, 8'd0, 8'd124);
        send_reply(RP_GOOD);
        set_config(8'd2, 8'd1, 8'd124, 8'd1);
        send_reply(RP_GOOD);
    endtask

    task automatic test_config_mid_frame();
        set_config(8'd9, 8'd3, 8'd0, 8'd1);
        build_reply(RP_GOOD);
        for (int k = 0; k < 8; k++) send_word(OP_BYTE, reply_bytes[k]);
        // shrink the frame below the current position, then bytes are dropped
        set_config(8'd9, 8'd1, 8'd0, 8'd1);
        repeat (3) send_word(OP_BYTE, 8'($urandom));
        send_word(OP_CLOSE, 8'h00);
        build_reply(RP_GOOD);
        for (int k = 0; k < 4; k++) send_word(OP_BYTE, reply_bytes[k]);
        set_config(8'd9, 8'd2, 8'd1, 8'd0);
        repeat (6) send_word(OP_BYTE, 8'($urandom));
        send_word(OP_CLOSE, 8'h00);
    endtask

    task automatic test_input_stall();
        set_config(8'd33, 8'd1, 8'd0, 8'd0);
        gaps_on    = 1'b0;
        hold_start = 1'b1;
        repeat (24) send_word(OP_CLOSE, 8'($urandom));
        send_reply(RP_GOOD);
        send_reply(RP_BAD_CRC);
        gaps_on = 1'b1;
        drain();
    endtask

    task automatic test_random_traffic();
        int r;
        int frames;
        int count;
        while (words_sent < WORD_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 80) count = $urandom_range(0, 5);
            else if (r < 96) count = $urandom_range(6, 30);
            else count = $urandom_range(100, 127);
            set_config(8'($urandom_range(1, 247)), 8'(count), pick_offset(count),
                       pick_offset(count));
            gaps_on = ($urandom_range(0, 3) != 0);
            frames  = (count >= 100) ? 2 : $urandom_range(8, 30);
            for (int f = 0; f < frames && words_sent < WORD_TARGET; f++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    send_reply(RP_GOOD);
                end else if (r < 90) begin
                    send_reply(reply_kind_t'($urandom_range(1, 11)));
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 9) < 6) send_word(OP_BYTE, 8'($urandom));
                        else send_word(OP_CLOSE, 8'($urandom));
                    end
                end
            end
            // leave a reply open across the next register change
            if ($urandom_range(0, 9) < 3) begin
                build_reply(RP_GOOD);
                for (int k = 0; k < $urandom_range(1, 8) && k < reply_bytes.size(); k++)
                    send_word(OP_BYTE, reply_bytes[k]);
            end
        end
    endtask

    initial begin
        live_cfg.slave_address         = RST_SLAVE_ADDRESS;
        live_cfg.register_count        = RST_REGISTER_COUNT;
        live_cfg.first_value_register  = RST_FIRST_VALUE;
        live_cfg.second_value_register = RST_SECOND_VALUE;
        first_good  = 32'd0;
        second_good = 32'd0;
        restart_window();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_header_checks();
        test_crc_check();
        test_non_finite();
        test_window_close();
        test_count_extremes();
        test_config_mid_frame();
        test_input_stall();
        test_random_traffic();
        send_word(OP_CLOSE, 8'h00);
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("modbus_rtu_read_reply_checker regression: pass");
        end else begin
            $display("modbus_rtu_read_reply_checker regression: fail");
        end
        $finish;
    end

endmodule
